// ----- rtl/iir_tdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_tdf_pkg
// Widths, formats and shared types of the transposed direct form II filter.
// ----------------------------------------------------------------------------
package iir_tdf_pkg;

  // Filter order built into this instance, 0 to MAX_ORDER
  localparam int FILTER_ORDER = 3;
  localparam int MAX_ORDER    = 3;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int FRAC_BITS = 20;
  localparam int STATE_W   = 48;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int ACC_W     = STATE_W + 2;

  localparam int NUM_REGS    = 7;
  localparam int REG_IDX_W   = 3;
  localparam int TAP_W       = 2;   // indexes the delay elements
  localparam int NUM_IDX_W   = 2;   // indexes b0..b3

  // Register indexes on the write port
  localparam logic [REG_IDX_W-1:0] REG_NUM_TAP0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_TAP1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_TAP2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_TAP3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEN_TAP1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEN_TAP2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DEN_TAP3 = 3'd6;

  localparam logic signed [COEF_W-1:0] NUM_TAP0_RESET = 24'sd1048576;

  // Request codes
  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // One operation for the shared multiply-accumulate unit
  typedef struct packed {
    logic             valid;
    logic             load;   // start from the preload value
    logic             neg;    // subtract the product
    logic             wb;     // accumulator is final after this product
    logic             is_y;   // final value is the output sum
    logic [TAP_W-1:0] tap;    // otherwise: delay element to update
  } mac_op_t;

  typedef struct packed {
    logic             valid;
    logic             is_y;
    logic [TAP_W-1:0] tap;
  } mac_res_t;

endpackage

// ----- rtl/iir_tdf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_tdf_if
// Valid/ready channels for filter requests and filtered samples.
// ----------------------------------------------------------------------------
interface iir_tdf_req_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       req_type;
  logic signed [iir_tdf_pkg::SAMPLE_W-1:0]    sample_in;

  modport source (output valid, output req_type, output sample_in, input ready);
  modport sink   (input valid, input req_type, input sample_in, output ready);
endinterface

interface iir_tdf_rsp_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [iir_tdf_pkg::SAMPLE_W-1:0]    sample_out;
  logic                                       saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

// ----- rtl/iir_tdf_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_transposed_df2_filter
// Transposed direct form II IIR filter with Q3.20 coefficients, 16-bit
// samples, 48-bit delay state and a saturating output.
// ----------------------------------------------------------------------------
// A filter request runs the single multiply-accumulate unit over the b0
// term, then one b and one a product per delay element; the sequencer
// waits out the unit's two pipeline stages once for the output sample (the
// feedback products need it) and once at the end. At order 0 there is no
// delay element and no final wait. A clear request zeroes the delay line
// and returns nothing. The filtered sample waits in its own register, so
// the next request is taken while the last result is unread; a request is
// held off while the sequencer is busy and while a second sample waits
// behind it. Coefficients are written through wr_en/wr_index/wr_data; the
// user must write them only while idle, as the block itself does not
// enforce it.
module iir_transposed_df2_filter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    wr_en,
  input  logic [iir_tdf_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [iir_tdf_pkg::COEF_W-1:0]          wr_data,
  iir_tdf_req_if.sink                             req,
  iir_tdf_rsp_if.source                           rsp
);
  import iir_tdf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_Y     = 3'd1;
  localparam logic [2:0] ST_WAITY = 3'd2;
  localparam logic [2:0] ST_TAP   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  localparam logic [TAP_W-1:0] LAST_TAP =
    TAP_W'((FILTER_ORDER > 0) ? FILTER_ORDER - 1 : 0);
  localparam logic [TAP_W-1:0] TOP_TAP = TAP_W'(MAX_ORDER - 1);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ST_HI = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ST_LO = -ST_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_HI  = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_LO  = -Y_HI - ACC_W'(1);

  logic signed [COEF_W-1:0]   num [MAX_ORDER+1];
  logic signed [COEF_W-1:0]   den [MAX_ORDER];
  logic signed [STATE_W-1:0]  delay_line [MAX_ORDER];

  logic [2:0]                 state;
  logic [TAP_W-1:0]           tap;
  logic                       phase;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] y;
  logic                       y_sat;
  logic                       pending;
  logic                       accept;

  mac_op_t                    op;
  mac_res_t                   res;
  logic signed [COEF_W-1:0]   coef;
  logic signed [SAMPLE_W-1:0] opnd;
  logic signed [STATE_W-1:0]  preload;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    y_full;
  logic signed [STATE_W-1:0]  w_clamped;

  assign req.ready = (state == ST_IDLE) && !pending;
  assign accept    = req.valid && req.ready;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num[0] <= NUM_TAP0_RESET;
      for (int i = 1; i <= MAX_ORDER; i++) num[i] <= '0;
      for (int i = 0; i < MAX_ORDER; i++) den[i] <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_NUM_TAP0: num[0] <= wr_data;
        REG_NUM_TAP1: num[1] <= wr_data;
        REG_NUM_TAP2: num[2] <= wr_data;
        REG_NUM_TAP3: num[3] <= wr_data;
        REG_DEN_TAP1: den[0] <= wr_data;
        REG_DEN_TAP2: den[1] <= wr_data;
        REG_DEN_TAP3: den[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // Issue one product per cycle to the shared unit in ST_Y and ST_TAP; none while waiting or idle
  always_comb begin
    op       = '0;
    coef     = num[0];
    opnd     = x;
    preload  = delay_line[0];
    op.tap   = tap;
    if (state == ST_Y) begin
      op.valid = 1'b1;
      op.load  = 1'b1;
      op.wb    = 1'b1;
      op.is_y  = 1'b1;
    end else if (state == ST_TAP) begin
      op.valid = 1'b1;
      if (!phase) begin
        coef    = num[NUM_IDX_W'(tap) + NUM_IDX_W'(1)];
        op.load = 1'b1;
        preload = (tap == TOP_TAP) ? '0 : delay_line[tap + TAP_W'(1)];
      end else begin
        coef  = den[tap];
        opnd  = y;
        op.neg = 1'b1;
        op.wb  = 1'b1;
      end
    end
  end

  iir_tdf_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .coef    (coef),
    .opnd    (opnd),
    .preload (preload),
    .acc     (acc),
    .res     (res)
  );

  // Round half up, then clip the output; clip delay elements to 48 bits
  always_comb begin
    rnd    = acc + ROUND_HALF;
    y_full = rnd >>> FRAC_BITS;
    if (acc > ST_HI) begin
      w_clamped = STATE_W'(ST_HI);
    end else if (acc < ST_LO) begin
      w_clamped = STATE_W'(ST_LO);
    end else begin
      w_clamped = STATE_W'(acc);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && req.req_type == REQ_FILTER) state <= ST_Y;
        end
        ST_Y: state <= ST_WAITY;
        ST_WAITY: begin
          if (res.valid && res.is_y) begin
            tap   <= '0;
            phase <= 1'b0;
            state <= (FILTER_ORDER > 0) ? ST_TAP : ST_IDLE;
          end
        end
        ST_TAP: begin
          phase <= !phase;
          if (phase) begin
            if (tap == LAST_TAP) begin
              state <= ST_DRAIN;
            end else begin
              tap <= tap + TAP_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (res.valid && !res.is_y && res.tap == LAST_TAP) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) x <= req.sample_in;
  end

  // Delay line: zero on clear, write back each finished element
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDER; i++) delay_line[i] <= '0;
    end else if (accept && req.req_type == REQ_CLEAR) begin
      for (int i = 0; i < MAX_ORDER; i++) delay_line[i] <= '0;
    end else if (res.valid && !res.is_y) begin
      delay_line[res.tap] <= w_clamped;
    end
  end

  // Output sample: hold it until the result register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (pending && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (res.valid && res.is_y) begin
        pending <= 1'b1;
      end else if (!rsp.valid || rsp.ready) begin
        pending <= 1'b0;
      end
    end
    if (pending && (!rsp.valid || rsp.ready)) begin
      rsp.sample_out <= y;
      rsp.saturated  <= y_sat;
    end
    if (res.valid && res.is_y) begin
      if (y_full > Y_HI) begin
        y     <= SAMPLE_W'(Y_HI);
        y_sat <= 1'b1;
      end else if (y_full < Y_LO) begin
        y     <= SAMPLE_W'(Y_LO);
        y_sat <= 1'b1;
      end else begin
        y     <= y_full[SAMPLE_W-1:0];
        y_sat <= 1'b0;
      end
    end
  end

  // Checks
  a_y_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.is_y |-> state == ST_WAITY)
    else $error("output sum finished outside its wait state");

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.is_y |-> (FILTER_ORDER > 0) && (int'(res.tap) < FILTER_ORDER))
    else $error("delay element written beyond the filter order");

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    pending |-> !req.ready)
    else $error("request taken while an output sample is unsent");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |->
      (rsp.sample_out == SAMPLE_W'(Y_HI)) || (rsp.sample_out == SAMPLE_W'(Y_LO)))
    else $error("saturation flag on a sample that is not at a rail");

endmodule

// ----- rtl/iir_tdf_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_tdf_mac
// Shared two-stage multiply-accumulate unit: registered product, then add or
// subtract into a wide accumulator that may start from a preload value.
// ----------------------------------------------------------------------------
module iir_tdf_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  iir_tdf_pkg::mac_op_t                   op,
  input  logic signed [iir_tdf_pkg::COEF_W-1:0]  coef,
  input  logic signed [iir_tdf_pkg::SAMPLE_W-1:0] opnd,
  input  logic signed [iir_tdf_pkg::STATE_W-1:0] preload,
  output logic signed [iir_tdf_pkg::ACC_W-1:0]   acc,
  output iir_tdf_pkg::mac_res_t                  res
);
  import iir_tdf_pkg::*;

  logic signed [PROD_W-1:0]  prod;
  logic signed [STATE_W-1:0] pre1;
  mac_op_t                   op1;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   term;

  always_ff @(posedge clk) begin
    if (rst) begin
      op1.valid <= 1'b0;
    end else begin
      op1.valid <= op.valid;
    end
    op1.load <= op.load;
    op1.neg  <= op.neg;
    op1.wb   <= op.wb;
    op1.is_y <= op.is_y;
    op1.tap  <= op.tap;
    prod     <= PROD_W'(coef) * PROD_W'(opnd);
    pre1     <= preload;
  end

  always_comb begin
    base = op1.load ? ACC_W'(pre1) : acc;
    term = op1.neg ? -ACC_W'(prod) : ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= op1.valid && op1.wb;
    end
    res.is_y <= op1.is_y;
    res.tap  <= op1.tap;
    if (op1.valid) begin
      acc <= base + term;
    end
  end

endmodule
